// ===== hdl/pcse_pkg.sv =====
// ----------------------------------------------------------------------------
// pcse_pkg
// shared types, constants and saturating arithmetic for the path command
// segment expander
// ----------------------------------------------------------------------------
package pcse_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [16:0] KAPPA_Q16 = 17'sd36195;
  localparam logic signed [16:0] HALF_Q16  = 17'sd32768;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_MOVE      = 4'd0,
    OP_LINE      = 4'd1,
    OP_QUAD      = 4'd2,
    OP_QUAD_SM   = 4'd3,
    OP_CUBIC     = 4'd4,
    OP_CUBIC_SM  = 4'd5,
    OP_RAT_QUAD  = 4'd6,
    OP_RAT_CUBIC = 4'd7,
    OP_ELLIPSE   = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    SEG_LINE      = 3'd0,
    SEG_QUAD      = 3'd1,
    SEG_CUBIC     = 3'd2,
    SEG_RAT_QUAD  = 3'd3,
    SEG_RAT_CUBIC = 3'd4
  } seg_kind_t;

  typedef logic signed [31:0] coord_t;

  // decoded command held in the queue
  typedef struct packed {
    op_t    op;
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    coord_t p3x;
    coord_t p3y;
    coord_t wa;
    coord_t wb;
    coord_t kx;
    coord_t ky;
  } cmd_t;

  // one segment record
  typedef struct packed {
    seg_kind_t kind;
    coord_t    x0;
    coord_t    y0;
    coord_t    x1;
    coord_t    y1;
    coord_t    x2;
    coord_t    y2;
    coord_t    x3;
    coord_t    y3;
    coord_t    w0;
    coord_t    w1;
    logic      last;
  } seg_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b, input logic sub);
    logic signed [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? SAT_MIN : SAT_MAX;
    end
    return s[31:0];
  endfunction

  // sat(2*c - d)
  function automatic coord_t reflect(input coord_t c, input coord_t d);
    logic signed [33:0] r;
    r = {c[31], c, 1'b0} - {{2{d[31]}}, d};
    if ((r[33:31] != 3'b000) && (r[33:31] != 3'b111)) begin
      return r[33] ? SAT_MIN : SAT_MAX;
    end
    return r[31:0];
  endfunction

endpackage

// ===== hdl/pcse_front.sv =====
// ----------------------------------------------------------------------------
// pcse_front
// accepts path commands, drops unknown operations and forms the kappa
// products of the ellipse radii
// ----------------------------------------------------------------------------
module pcse_front import pcse_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic [3:0]   in_tuser,
  input  logic         q_full,
  output logic         q_push,
  output cmd_t         q_data
);

  logic  fv_r, fv_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic  accept;
  logic  known;
  coord_t rx, ry;
  logic signed [48:0] prod_x, prod_y;

  assign in_tready = !fv_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = fv_r && !q_full;
  assign q_data    = cmd_r;

  always_comb begin
    unique case (in_tuser)
      OP_MOVE, OP_LINE, OP_QUAD, OP_QUAD_SM, OP_CUBIC, OP_CUBIC_SM,
      OP_RAT_QUAD, OP_RAT_CUBIC, OP_ELLIPSE: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign rx     = in_tdata[95:64];
  assign ry     = in_tdata[127:96];
  assign prod_x = 49'(rx) * 49'(KAPPA_Q16) + 49'(HALF_Q16);
  assign prod_y = 49'(ry) * 49'(KAPPA_Q16) + 49'(HALF_Q16);

  always_comb begin
    cmd_nxt     = cmd_r;
    cmd_nxt.op  = op_t'(in_tuser);
    cmd_nxt.p1x = in_tdata[31:0];
    cmd_nxt.p1y = in_tdata[63:32];
    cmd_nxt.p2x = rx;
    cmd_nxt.p2y = ry;
    cmd_nxt.p3x = in_tdata[159:128];
    cmd_nxt.p3y = in_tdata[191:160];
    cmd_nxt.wa  = in_tdata[223:192];
    cmd_nxt.wb  = in_tdata[255:224];
    cmd_nxt.kx  = prod_x[47:16];
    cmd_nxt.ky  = prod_y[47:16];
    if (accept) begin
      fv_nxt = known;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end else begin
      fv_nxt = fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== hdl/pcse_fifo.sv =====
// ----------------------------------------------------------------------------
// pcse_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module pcse_fifo import pcse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hdl/pcse_back.sv =====
// ----------------------------------------------------------------------------
// pcse_back
// holds the current and control points and expands queued commands into
// segment records behind an output register
// ----------------------------------------------------------------------------
module pcse_back import pcse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t head,
  output logic q_pop,
  output logic seg_valid,
  input  logic seg_ready,
  output seg_t seg
);

  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t ctl_x_r, ctl_x_nxt, ctl_y_r, ctl_y_nxt;
  logic [1:0] beat_r, beat_nxt;
  logic   ov_r, ov_nxt;
  seg_t   seg_r, seg_nxt;
  logic   can_emit, emit;
  coord_t rfx, rfy;
  coord_t sxp, sxm, skp, skm, syp, sym, tkp, tkm;

  assign can_emit  = !ov_r || seg_ready;
  assign seg_valid = ov_r;
  assign seg       = seg_r;

  assign rfx = reflect(cur_x_r, ctl_x_r);
  assign rfy = reflect(cur_y_r, ctl_y_r);
  assign sxp = sat_add(head.p1x, head.p2x, 1'b0);
  assign sxm = sat_add(head.p1x, head.p2x, 1'b1);
  assign skp = sat_add(head.p1x, head.kx, 1'b0);
  assign skm = sat_add(head.p1x, head.kx, 1'b1);
  assign syp = sat_add(head.p1y, head.p2y, 1'b0);
  assign sym = sat_add(head.p1y, head.p2y, 1'b1);
  assign tkp = sat_add(head.p1y, head.ky, 1'b0);
  assign tkm = sat_add(head.p1y, head.ky, 1'b1);

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    beat_nxt  = beat_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    ctl_x_nxt = ctl_x_r;
    ctl_y_nxt = ctl_y_r;
    seg_nxt   = '0;
    seg_nxt.x0   = cur_x_r;
    seg_nxt.y0   = cur_y_r;
    seg_nxt.last = 1'b1;
    if (!q_empty) begin
      unique case (head.op)
        OP_MOVE: begin
          q_pop     = 1'b1;
          cur_x_nxt = head.p1x;
          cur_y_nxt = head.p1y;
          ctl_x_nxt = head.p1x;
          ctl_y_nxt = head.p1y;
        end
        OP_LINE: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_LINE;
          seg_nxt.x1   = head.p1x;
          seg_nxt.y1   = head.p1y;
          cur_x_nxt    = head.p1x;
          cur_y_nxt    = head.p1y;
          ctl_x_nxt    = head.p1x;
          ctl_y_nxt    = head.p1y;
        end
        OP_QUAD, OP_QUAD_SM: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_QUAD;
          seg_nxt.x1   = (head.op == OP_QUAD_SM) ? rfx : head.p1x;
          seg_nxt.y1   = (head.op == OP_QUAD_SM) ? rfy : head.p1y;
          seg_nxt.x2   = head.p2x;
          seg_nxt.y2   = head.p2y;
          cur_x_nxt    = head.p2x;
          cur_y_nxt    = head.p2y;
          ctl_x_nxt    = seg_nxt.x1;
          ctl_y_nxt    = seg_nxt.y1;
        end
        OP_CUBIC, OP_CUBIC_SM: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_CUBIC;
          seg_nxt.x1   = (head.op == OP_CUBIC_SM) ? rfx : head.p1x;
          seg_nxt.y1   = (head.op == OP_CUBIC_SM) ? rfy : head.p1y;
          seg_nxt.x2   = head.p2x;
          seg_nxt.y2   = head.p2y;
          seg_nxt.x3   = head.p3x;
          seg_nxt.y3   = head.p3y;
          cur_x_nxt    = head.p3x;
          cur_y_nxt    = head.p3y;
          ctl_x_nxt    = head.p2x;
          ctl_y_nxt    = head.p2y;
        end
        OP_RAT_QUAD: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_RAT_QUAD;
          seg_nxt.x1   = head.p1x;
          seg_nxt.y1   = head.p1y;
          seg_nxt.x2   = head.p2x;
          seg_nxt.y2   = head.p2y;
          seg_nxt.w0   = head.wa;
          cur_x_nxt    = head.p2x;
          cur_y_nxt    = head.p2y;
          ctl_x_nxt    = head.p2x;
          ctl_y_nxt    = head.p2y;
        end
        OP_RAT_CUBIC: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_RAT_CUBIC;
          seg_nxt.x1   = head.p1x;
          seg_nxt.y1   = head.p1y;
          seg_nxt.x2   = head.p2x;
          seg_nxt.y2   = head.p2y;
          seg_nxt.x3   = head.p3x;
          seg_nxt.y3   = head.p3y;
          seg_nxt.w0   = head.wa;
          seg_nxt.w1   = head.wb;
          cur_x_nxt    = head.p3x;
          cur_y_nxt    = head.p3y;
          ctl_x_nxt    = head.p3x;
          ctl_y_nxt    = head.p3y;
        end
        OP_ELLIPSE: begin
          emit         = can_emit;
          seg_nxt.kind = SEG_CUBIC;
          seg_nxt.last = (beat_r == 2'd3);
          case (beat_r)
            2'd0: begin
              seg_nxt.x0 = head.p1x;
              seg_nxt.y0 = syp;
              seg_nxt.x1 = skp;
              seg_nxt.y1 = syp;
              seg_nxt.x2 = sxp;
              seg_nxt.y2 = tkp;
              seg_nxt.x3 = sxp;
              seg_nxt.y3 = head.p1y;
            end
            2'd1: begin
              seg_nxt.x1 = sxp;
              seg_nxt.y1 = tkm;
              seg_nxt.x2 = skp;
              seg_nxt.y2 = sym;
              seg_nxt.x3 = head.p1x;
              seg_nxt.y3 = sym;
            end
            2'd2: begin
              seg_nxt.x1 = skm;
              seg_nxt.y1 = sym;
              seg_nxt.x2 = sxm;
              seg_nxt.y2 = tkm;
              seg_nxt.x3 = sxm;
              seg_nxt.y3 = head.p1y;
            end
            default: begin
              seg_nxt.x1 = sxm;
              seg_nxt.y1 = tkp;
              seg_nxt.x2 = skm;
              seg_nxt.y2 = syp;
              seg_nxt.x3 = head.p1x;
              seg_nxt.y3 = syp;
            end
          endcase
          cur_x_nxt = seg_nxt.x3;
          cur_y_nxt = seg_nxt.y3;
          ctl_x_nxt = seg_nxt.x2;
          ctl_y_nxt = seg_nxt.y2;
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
      if (head.op == OP_ELLIPSE) begin
        if (emit) begin
          beat_nxt = beat_r + 1'b1;
          q_pop    = (beat_r == 2'd3);
        end
      end else if (head.op != OP_MOVE) begin
        q_pop = emit;
      end
      if (!q_pop && !emit) begin
        cur_x_nxt = cur_x_r;
        cur_y_nxt = cur_y_r;
        ctl_x_nxt = ctl_x_r;
        ctl_y_nxt = ctl_y_r;
      end
    end
    ov_nxt = emit ? 1'b1 : (seg_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      ctl_x_r <= '0;
      ctl_y_r <= '0;
      beat_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      ctl_x_r <= ctl_x_nxt;
      ctl_y_r <= ctl_y_nxt;
      beat_r  <= beat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

// ===== hdl/path_command_segment_expander.sv =====
// ----------------------------------------------------------------------------
// path_command_segment_expander
// turns vector path commands into line, quadratic, cubic and rational
// segment records while tracking the current and control points
// ----------------------------------------------------------------------------
// usage
//   in_*  : one path command per transaction, operation on in_tuser
//   out_* : one segment per transaction, kind on out_tuser, out_tlast on the
//           final segment of a command
//   a command is held in the front register at its input transaction, then
//   written into the queue, and its segment is then loaded into the output
//   register, whose valid bit drives out_tvalid
//   one command per cycle is accepted unless the queue is full; an
//   ellipse holds the back end for four cubic segments while the four-entry
//   queue keeps taking commands; move and unknown operations give no segment
//   reset clears the current and control points to zero and empties the
//   queue and output register
//   when the receiver stalls the output register holds its segment, the
//   queue fills and in_tready falls once the front register is also held
// ----------------------------------------------------------------------------
module path_command_segment_expander import pcse_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, weight_a, weight_b
  input  logic [255:0] in_tdata,
  // operation
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x0, out_y0, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3,
  // out_weight0, out_weight1
  output logic [319:0] out_tdata,
  // seg_kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_data, head;
  seg_t seg;

  pcse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  pcse_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  pcse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .q_pop     (q_pop),
    .seg_valid (out_tvalid),
    .seg_ready (out_tready),
    .seg       (seg)
  );

  assign out_tuser = seg.kind;
  assign out_tlast = seg.last;
  assign out_tdata = {seg.w1, seg.w0, seg.y3, seg.x3, seg.y2, seg.x2,
                      seg.y1, seg.x1, seg.y0, seg.x0};

endmodule
